### sv/integer_to_text_formatter_macros.svh
// ----------------------------------------------------------------------------
// integer_to_text_formatter_macros
// assertion macros shared by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TO_TEXT_FORMATTER_MACROS_SVH

// same-cycle implication
`define ITF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// shared constants, types and helpers of the integer to text formatter
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int ValueBitsDefault = 32;
  localparam int ValueWidth       = 32;
  localparam int BaseWidth        = 5;
  localparam int FieldWidth       = 7;
  localparam int FlagWidth        = 7;
  localparam int CharWidth        = 8;
  localparam int DigitWidth       = 4;
  localparam int SumWidth         = 8;
  localparam int OutCntWidth      = 6;
  localparam int MaxChars         = 64;
  localparam int MinBase          = 2;
  localparam int MaxBase          = 16;
  localparam int OctalBase        = 8;

  localparam int FlagLeft   = 0;
  localparam int FlagZero   = 1;
  localparam int FlagPlus   = 2;
  localparam int FlagSpace  = 3;
  localparam int FlagAlt    = 4;
  localparam int FlagLower  = 5;
  localparam int FlagSigned = 6;

  localparam logic [CharWidth-1:0] ChSpace  = 8'h20;
  localparam logic [CharWidth-1:0] ChPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] ChMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] ChZero   = 8'h30;
  localparam logic [CharWidth-1:0] ChUpperA = 8'h41;
  localparam logic [CharWidth-1:0] ChLowerA = 8'h61;
  localparam logic [CharWidth-1:0] ChUpperX = 8'h58;
  localparam logic [CharWidth-1:0] ChLowerX = 8'h78;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic [DigitWidth-1:0] digit;
  } stack_ctrl_t;

  function automatic logic [CharWidth-1:0] digit_char(logic [DigitWidth-1:0] d, logic lower);
    logic [CharWidth-1:0] ext;
    ext = {{(CharWidth-DigitWidth){1'b0}}, d};
    if (d < 4'd10) begin
      return ChZero + ext;
    end
    return (lower ? ChLowerA : ChUpperA) + ext - 8'd10;
  endfunction

endpackage

### sv/itf_divider.sv
// ----------------------------------------------------------------------------
// itf_divider
// shared restoring divider, one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
module itf_divider #(
  parameter int ValueBits = itf_pkg::ValueBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ValueBits-1:0]                dividend_i,
  input  logic [itf_pkg::BaseWidth-1:0]       divisor_i,
  output itf_pkg::div_stat_t                  stat_o,
  output logic [ValueBits-1:0]                quotient_o,
  output logic [itf_pkg::DigitWidth-1:0]      remainder_o
);

  localparam int CntWidth = $clog2(ValueBits + 1);

  logic [ValueBits-1:0]               quo_q, quo_d;
  logic [itf_pkg::DigitWidth-1:0]     rem_q, rem_d;
  logic [CntWidth-1:0]                cnt_q, cnt_d;
  logic                               done_q, done_d;
  logic [itf_pkg::BaseWidth-1:0]      trial;
  logic [itf_pkg::BaseWidth-1:0]      diff;
  logic                               ge;

  always_comb begin
    trial = {rem_q, quo_q[ValueBits-1]};
    ge    = (trial >= divisor_i);
    diff  = trial - divisor_i;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CntWidth'(ValueBits);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[ValueBits-2:0], ge};
      rem_d = ge ? diff[itf_pkg::DigitWidth-1:0] : trial[itf_pkg::DigitWidth-1:0];
      cnt_d = cnt_q - 1'b1;
    end
    done_d = !start_i && (cnt_q == CntWidth'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy  = (cnt_q != '0);
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

### sv/itf_digit_stack.sv
// ----------------------------------------------------------------------------
// itf_digit_stack
// last-in first-out shift line of digits, read at the head only
// ----------------------------------------------------------------------------
module itf_digit_stack #(
  parameter int Depth = itf_pkg::ValueBitsDefault
) (
  input  logic                           clk_i,
  input  itf_pkg::stack_ctrl_t           ctrl_i,
  output logic [itf_pkg::DigitWidth-1:0] top_o
);

  logic [itf_pkg::DigitWidth-1:0] ent_q [Depth];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      ent_q[0] <= ctrl_i.digit;
      for (int i = 1; i < Depth; i++) begin
        ent_q[i] <= ent_q[i-1];
      end
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
      ent_q[Depth-1] <= '0;
    end
  end

  assign top_o = ent_q[0];

endmodule

### sv/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter
// printf-style integer conversion, one ascii character per result
//
//   channel  direction  handshake             payload
//   command  in         start_i / busy_o      value_i base_i width_i format_flags_i
//   result   out        valid_o (strobe)      character_o last_o
//
// an item runs the digit loop once for each of its D digits, then plans, then emits its L chars
// the digit loop runs through the one shared divider, one quotient bit a cycle
// busy_o stays high from transfer until the last character is driven
// reset is asynchronous; after it the block is idle with no pending output
// results cannot be stalled; each is shown for one cycle
// ----------------------------------------------------------------------------
`include "integer_to_text_formatter_macros.svh"

module integer_to_text_formatter #(
  parameter int ValueBits = itf_pkg::ValueBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [itf_pkg::ValueWidth-1:0]     value_i,
  input  logic [itf_pkg::BaseWidth-1:0]      base_i,
  input  logic [itf_pkg::FieldWidth-1:0]     width_i,
  input  logic [itf_pkg::FlagWidth-1:0]      format_flags_i,
  output logic                               valid_o,
  output logic [itf_pkg::CharWidth-1:0]      character_o,
  output logic                               last_o
);

  localparam int NdWidth = $clog2(ValueBits + 1);
  localparam int FW      = itf_pkg::FieldWidth;
  localparam int CW      = itf_pkg::CharWidth;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PLAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    KIND_SPACE,
    KIND_ZERO,
    KIND_PREFIX,
    KIND_DIGIT
  } kind_e;

  state_e                          state_q, state_d;
  logic                            launch_q, launch_d;
  logic [ValueBits-1:0]            mag_q, mag_d;
  logic [itf_pkg::BaseWidth-1:0]   base_q, base_d;
  logic [FW-1:0]                   width_q, width_d;
  logic                            left_q, left_d;
  logic                            zero_q, zero_d;
  logic                            lower_q, lower_d;
  logic [CW-1:0]                   prefix_q [4];
  logic [CW-1:0]                   prefix_d [4];
  logic [1:0]                      np_q, np_d;
  logic [NdWidth-1:0]              nd_q, nd_d;
  kind_e                           kind_q [4];
  kind_e                           kind_d [4];
  logic [FW-1:0]                   seg_len_q [4];
  logic [FW-1:0]                   seg_len_d [4];
  logic [1:0]                      seg_idx_q, seg_idx_d;
  logic [FW-1:0]                   pos_q, pos_d;
  logic [itf_pkg::OutCntWidth-1:0] out_cnt_q, out_cnt_d;
  logic [itf_pkg::OutCntWidth-1:0] last_idx_q, last_idx_d;
  logic                            valid_q, valid_d;
  logic [CW-1:0]                   char_q, char_d;
  logic                            last_q, last_d;

  itf_pkg::div_stat_t              div_stat;
  logic [ValueBits-1:0]            div_quo;
  logic [itf_pkg::DigitWidth-1:0]  div_rem;
  itf_pkg::stack_ctrl_t            stk_ctrl;
  logic [itf_pkg::DigitWidth-1:0]  stk_top;

  logic                            accept;
  logic [ValueBits-1:0]            v_in;
  logic                            neg_in;
  logic                            base_ok;
  logic                            alt8, alt16;
  logic [itf_pkg::SumWidth-1:0]    sum;
  logic [itf_pkg::SumWidth-1:0]    total;
  logic [FW-1:0]                   npad;
  logic [FW-1:0]                   cur_len;
  kind_e                           cur_kind;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d    = state_q;
    launch_d   = 1'b0;
    mag_d      = mag_q;
    base_d     = base_q;
    width_d    = width_q;
    left_d     = left_q;
    zero_d     = zero_q;
    lower_d    = lower_q;
    prefix_d   = prefix_q;
    np_d       = np_q;
    nd_d       = nd_q;
    kind_d     = kind_q;
    seg_len_d  = seg_len_q;
    seg_idx_d  = seg_idx_q;
    pos_d      = pos_q;
    out_cnt_d  = out_cnt_q;
    last_idx_d = last_idx_q;
    valid_d    = 1'b0;
    char_d     = char_q;
    last_d     = 1'b0;
    stk_ctrl   = '0;

    v_in    = ValueBits'(value_i);
    neg_in  = format_flags_i[itf_pkg::FlagSigned] && v_in[ValueBits-1];
    base_ok = (base_i >= itf_pkg::BaseWidth'(itf_pkg::MinBase))
           && (base_i <= itf_pkg::BaseWidth'(itf_pkg::MaxBase));
    alt8    = format_flags_i[itf_pkg::FlagAlt]
           && (base_i == itf_pkg::BaseWidth'(itf_pkg::OctalBase));
    alt16   = format_flags_i[itf_pkg::FlagAlt]
           && (base_i == itf_pkg::BaseWidth'(itf_pkg::MaxBase));

    sum      = itf_pkg::SumWidth'(nd_q) + itf_pkg::SumWidth'(np_q);
    total    = ({1'b0, width_q} > sum) ? {1'b0, width_q} : sum;
    npad     = FW'(total - sum);
    cur_len  = seg_len_q[seg_idx_q];
    cur_kind = kind_q[seg_idx_q];

    unique case (state_q)
      S_IDLE: begin
        if (accept && base_ok) begin
          mag_d    = neg_in ? (ValueBits'(0) - v_in) : v_in;
          base_d   = base_i;
          width_d  = width_i;
          left_d   = format_flags_i[itf_pkg::FlagLeft];
          zero_d   = format_flags_i[itf_pkg::FlagZero] && !format_flags_i[itf_pkg::FlagLeft];
          lower_d  = format_flags_i[itf_pkg::FlagLower];
          nd_d     = '0;
          np_d     = '0;
          for (int i = 0; i < 4; i++) begin
            prefix_d[i] = itf_pkg::ChSpace;
          end
          if (neg_in) begin
            prefix_d[0] = itf_pkg::ChMinus;
            np_d        = 2'd1;
          end else if (format_flags_i[itf_pkg::FlagPlus]) begin
            prefix_d[0] = itf_pkg::ChPlus;
            np_d        = 2'd1;
          end else if (format_flags_i[itf_pkg::FlagSpace]) begin
            prefix_d[0] = itf_pkg::ChSpace;
            np_d        = 2'd1;
          end
          if (alt8 || alt16) begin
            prefix_d[np_d] = itf_pkg::ChZero;
            np_d           = np_d + 2'd1;
          end
          if (alt16) begin
            prefix_d[np_d] = format_flags_i[itf_pkg::FlagLower] ? itf_pkg::ChLowerX
                                                                 : itf_pkg::ChUpperX;
            np_d           = np_d + 2'd1;
          end
          launch_d = 1'b1;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push  = 1'b1;
          stk_ctrl.digit = div_rem;
          nd_d           = nd_q + 1'b1;
          mag_d          = div_quo;
          if (div_quo == '0) begin
            state_d = S_PLAN;
          end else begin
            launch_d = 1'b1;
          end
        end
      end
      S_PLAN: begin
        seg_idx_d    = '0;
        pos_d        = '0;
        out_cnt_d    = '0;
        last_idx_d   = (total > itf_pkg::SumWidth'(itf_pkg::MaxChars))
                     ? itf_pkg::OutCntWidth'(itf_pkg::MaxChars - 1)
                     : itf_pkg::OutCntWidth'(total - 1'b1);
        kind_d[3]    = KIND_SPACE;
        seg_len_d[3] = '0;
        if (left_q) begin
          kind_d[0] = KIND_PREFIX; seg_len_d[0] = FW'(np_q);
          kind_d[1] = KIND_DIGIT;  seg_len_d[1] = FW'(nd_q);
          kind_d[2] = KIND_SPACE;  seg_len_d[2] = npad;
        end else if (zero_q) begin
          kind_d[0] = KIND_PREFIX; seg_len_d[0] = FW'(np_q);
          kind_d[1] = KIND_ZERO;   seg_len_d[1] = npad;
          kind_d[2] = KIND_DIGIT;  seg_len_d[2] = FW'(nd_q);
        end else begin
          kind_d[0] = KIND_SPACE;  seg_len_d[0] = npad;
          kind_d[1] = KIND_PREFIX; seg_len_d[1] = FW'(np_q);
          kind_d[2] = KIND_DIGIT;  seg_len_d[2] = FW'(nd_q);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (pos_q >= cur_len) begin
          seg_idx_d = seg_idx_q + 1'b1;
          pos_d     = '0;
        end else begin
          valid_d   = 1'b1;
          pos_d     = pos_q + 1'b1;
          out_cnt_d = out_cnt_q + 1'b1;
          last_d    = (out_cnt_q == last_idx_q);
          unique case (cur_kind)
            KIND_SPACE:  char_d = itf_pkg::ChSpace;
            KIND_ZERO:   char_d = itf_pkg::ChZero;
            KIND_PREFIX: char_d = prefix_q[pos_q[1:0]];
            KIND_DIGIT: begin
              char_d       = itf_pkg::digit_char(stk_top, lower_q);
              stk_ctrl.pop = 1'b1;
            end
            default:     char_d = itf_pkg::ChSpace;
          endcase
          if (last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    base_q     <= base_d;
    width_q    <= width_d;
    left_q     <= left_d;
    zero_q     <= zero_d;
    lower_q    <= lower_d;
    prefix_q   <= prefix_d;
    np_q       <= np_d;
    nd_q       <= nd_d;
    kind_q     <= kind_d;
    seg_len_q  <= seg_len_d;
    seg_idx_q  <= seg_idx_d;
    pos_q      <= pos_d;
    out_cnt_q  <= out_cnt_d;
    last_idx_q <= last_idx_d;
    char_q     <= char_d;
  end

  itf_divider #(
    .ValueBits (ValueBits)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (launch_q),
    .dividend_i  (mag_q),
    .divisor_i   (base_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  itf_digit_stack #(
    .Depth (ValueBits)
  ) u_digit_stack (
    .clk_i  (clk_i),
    .ctrl_i (stk_ctrl),
    .top_o  (stk_top)
  );

  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  `ITF_ASSERT_NOW(a_done_in_div, div_stat.done, state_q == S_DIV, "divider done outside digit loop")
  `ITF_ASSERT_NOW(a_rem_below_base, div_stat.done, div_rem < base_q, "remainder not below base")
  `ITF_ASSERT_NOW(a_last_frees, valid_o && last_o, state_q == S_IDLE, "busy after last transfer")
  `ITF_ASSERT_NEXT(a_launch_busy, launch_q, div_stat.busy, "divider not running after launch")

endmodule
